[rtl/md5h_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// md5h_pkg
// Shared types, constants and round tables for the MD5 message hasher.
// ---------------------------------------------------------------------------
package md5h_pkg;

    // Input word: one message byte plus framing flags
    typedef struct packed {
        logic       has_byte;
        logic [7:0] data_byte;
        logic       last;
    } in_word_t;

    // Output word: half of the digest
    typedef struct packed {
        logic [63:0] digest_half;
        logic        half_last;
    } out_word_t;

    // Datapath operation selected by the microcode word of each step
    typedef enum logic [3:0] {
        OP_IDLE,
        OP_INIT,
        OP_ROUND,
        OP_FOLD,
        OP_RESUME,
        OP_MARK,
        OP_ZERO,
        OP_LEN_LO,
        OP_LEN_HI,
        OP_EMIT0,
        OP_EMIT1
    } op_t;

    // Status flags the sequencer branches on
    typedef struct packed {
        logic acc_full;     // accepted byte completes a block
        logic acc_last;     // accepted word closes the message
        logic more_rounds;  // round counter not at the final round
        logic final_blk;    // compression in flight is the last one
        logic extra_blk;    // padding spills into a second block
        logic pend_last;    // message closed, padding still owed
        logic zero_done;    // padding sweep reached the end of the block
        logic out_free;     // output register can take a word
    } stat_t;

    // Chaining word initial values
    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;

    localparam logic [7:0] PAD_MARK = 8'h80;

    // Per-round additive constant
    function automatic logic [31:0] md5h_k(input logic [5:0] r);
        logic [31:0] k;
        case (r)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    // Message word index used by each round
    function automatic logic [3:0] md5h_g(input logic [5:0] r);
        logic [3:0] lo;
        logic [3:0] g;
        lo = r[3:0];
        case (r[5:4])
            2'd0:    g = lo;
            2'd1:    g = lo * 4'd5 + 4'd1;
            2'd2:    g = lo * 4'd3 + 4'd5;
            default: g = lo * 4'd7;
        endcase
        return g;
    endfunction

    // Left rotate amount per round
    function automatic logic [4:0] md5h_s(input logic [5:0] r);
        logic [4:0] s;
        case ({r[5:4], r[1:0]})
            4'd0:  s = 5'd7;   4'd1:  s = 5'd12;
            4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;   4'd5:  s = 5'd9;
            4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;   4'd9:  s = 5'd11;
            4'd10: s = 5'd16;  4'd11: s = 5'd23;
            4'd12: s = 5'd6;   4'd13: s = 5'd10;
            4'd14: s = 5'd15;  4'd15: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

[rtl/md5h_sequencer.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// md5h_sequencer
// Step counter and control store. Each step's control word picks the
// datapath operation and up to two conditional jumps plus a default next.
// ---------------------------------------------------------------------------
module md5h_sequencer
    import md5h_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire stat_t stat,
    output op_t        op
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_ROUND,
        ST_FOLD,
        ST_RESUME,
        ST_MARK,
        ST_ZERO,
        ST_LEN_LO,
        ST_LEN_HI,
        ST_EMIT0,
        ST_EMIT1
    } step_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ACC_FULL,
        C_ACC_LAST,
        C_MORE_ROUNDS,
        C_FINAL,
        C_EXTRA,
        C_PEND,
        C_ZERO_EXTRA,
        C_ZERO_DONE,
        C_OUT_FREE
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t c1;
        step_t t1;
        cond_t c2;
        step_t t2;
        step_t nxt;
    } mc_word_t;

    // Control store
    function automatic mc_word_t mc_rom(input step_t s);
        mc_word_t w;
        case (s)
            ST_IDLE:   w = '{OP_IDLE,   C_ACC_FULL,    ST_INIT,   C_ACC_LAST,  ST_MARK,
                             ST_IDLE};
            ST_INIT:   w = '{OP_INIT,   C_NEVER,       ST_IDLE,   C_NEVER,     ST_IDLE,
                             ST_ROUND};
            ST_ROUND:  w = '{OP_ROUND,  C_MORE_ROUNDS, ST_ROUND,  C_NEVER,     ST_IDLE,
                             ST_FOLD};
            ST_FOLD:   w = '{OP_FOLD,   C_FINAL,       ST_EMIT0,  C_EXTRA,     ST_ZERO,
                             ST_RESUME};
            ST_RESUME: w = '{OP_RESUME, C_PEND,        ST_MARK,   C_NEVER,     ST_IDLE,
                             ST_IDLE};
            ST_MARK:   w = '{OP_MARK,   C_NEVER,       ST_IDLE,   C_NEVER,     ST_IDLE,
                             ST_ZERO};
            ST_ZERO:   w = '{OP_ZERO,   C_ZERO_EXTRA,  ST_INIT,   C_ZERO_DONE, ST_LEN_LO,
                             ST_ZERO};
            ST_LEN_LO: w = '{OP_LEN_LO, C_NEVER,       ST_IDLE,   C_NEVER,     ST_IDLE,
                             ST_LEN_HI};
            ST_LEN_HI: w = '{OP_LEN_HI, C_NEVER,       ST_IDLE,   C_NEVER,     ST_IDLE,
                             ST_INIT};
            ST_EMIT0:  w = '{OP_EMIT0,  C_OUT_FREE,    ST_EMIT1,  C_NEVER,     ST_IDLE,
                             ST_EMIT0};
            ST_EMIT1:  w = '{OP_EMIT1,  C_OUT_FREE,    ST_IDLE,   C_NEVER,     ST_IDLE,
                             ST_EMIT1};
            default:   w = '{OP_IDLE,   C_NEVER,       ST_IDLE,   C_NEVER,     ST_IDLE,
                             ST_IDLE};
        endcase
        return w;
    endfunction

    function automatic logic cond_true(input cond_t c, input stat_t st);
        logic t;
        case (c)
            C_ACC_FULL:    t = st.acc_full;
            C_ACC_LAST:    t = st.acc_last;
            C_MORE_ROUNDS: t = st.more_rounds;
            C_FINAL:       t = st.final_blk;
            C_EXTRA:       t = st.extra_blk;
            C_PEND:        t = st.pend_last;
            C_ZERO_EXTRA:  t = st.zero_done && st.extra_blk;
            C_ZERO_DONE:   t = st.zero_done;
            C_OUT_FREE:    t = st.out_free;
            default:       t = 1'b0;
        endcase
        return t;
    endfunction

    step_t    step_reg;
    step_t    step_next;
    mc_word_t word;

    assign word = mc_rom(step_reg);
    assign op   = word.op;

    // Branch select: first jump, second jump, then default
    always_comb
    begin
        if (cond_true(word.c1, stat))
        begin
            step_next = word.t1;
        end
        else if (cond_true(word.c2, stat))
        begin
            step_next = word.t2;
        end
        else
        begin
            step_next = word.nxt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule
`default_nettype wire

[rtl/md5h_datapath.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// md5h_datapath
// Block buffer, byte counter, chaining and working words, one MD5 round
// per cycle, padding writes and the output register.
// ---------------------------------------------------------------------------
module md5h_datapath
    import md5h_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire op_t       op,
    output stat_t          stat,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_word_t  in_word,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_word_t      out_word
);

    // Block buffer, byte-lane writes, registered read
    logic [31:0] mem [16];
    logic        we;
    logic [3:0]  waddr;
    logic [3:0]  wbe;
    logic [31:0] wdata;
    logic [3:0]  rd_addr;
    logic [31:0] rdata_reg;

    // Control state
    logic [31:0] chain_reg [4];
    logic [31:0] chain_next [4];
    logic [60:0] count_reg, count_next;
    logic [5:0]  round_reg, round_next;
    logic [4:0]  wptr_reg, wptr_next;
    logic        pend_reg, pend_next;
    logic        extra_reg, extra_next;
    logic        final_reg, final_next;
    logic        out_valid_reg, out_valid_next;

    // Payload state
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [31:0] a_next, b_next, c_next, d_next;
    out_word_t   out_word_reg, out_word_next;

    logic        accept;
    logic        out_free;
    logic [5:0]  pos;
    logic [31:0] f_val;
    logic [31:0] sum;
    logic [63:0] rot_wide;
    logic [31:0] rot;

    assign in_ready  = (op == OP_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign pos       = count_reg[5:0];
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    assign stat.acc_full    = accept && in_word.has_byte && (pos == 6'h3f);
    assign stat.acc_last    = accept && in_word.last;
    assign stat.more_rounds = (round_reg != 6'h3f);
    assign stat.final_blk   = final_reg;
    assign stat.extra_blk   = extra_reg;
    assign stat.pend_last   = pend_reg;
    assign stat.zero_done   = wptr_reg[4];
    assign stat.out_free    = out_free;

    // One round: F, four-way add, rotate
    always_comb
    begin
        case (round_reg[5:4])
            2'd0:    f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1:    f_val = (d_reg & b_reg) | (~d_reg & c_reg);
            2'd2:    f_val = b_reg ^ c_reg ^ d_reg;
            default: f_val = c_reg ^ (b_reg | ~d_reg);
        endcase
        sum      = f_val + a_reg + md5h_k(round_reg) + rdata_reg;
        rot_wide = {sum, sum} << md5h_s(round_reg);
        rot      = rot_wide[63:32];
    end

    // Next-state logic per operation
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            chain_next[i] = chain_reg[i];
        end
        count_next     = count_reg;
        round_next     = round_reg;
        wptr_next      = wptr_reg;
        pend_next      = pend_reg;
        extra_next     = extra_reg;
        final_next     = final_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        d_next         = d_reg;
        out_word_next  = out_word_reg;
        out_valid_next = out_valid_reg && !out_ready;
        we             = 1'b0;
        waddr          = pos[5:2];
        wbe            = 4'b0000;
        wdata          = 32'h0;
        rd_addr        = md5h_g(6'd0);

        case (op)
            OP_IDLE:
            begin
                if (accept && in_word.has_byte)
                begin
                    we         = 1'b1;
                    wbe        = 4'b0001 << pos[1:0];
                    wdata      = {4{in_word.data_byte}};
                    count_next = count_reg + 61'd1;
                end
                if (accept && in_word.last)
                begin
                    pend_next = 1'b1;
                end
            end
            OP_INIT:
            begin
                a_next     = chain_reg[0];
                b_next     = chain_reg[1];
                c_next     = chain_reg[2];
                d_next     = chain_reg[3];
                round_next = 6'd0;
            end
            OP_ROUND:
            begin
                rd_addr    = md5h_g(round_reg + 6'd1);
                a_next     = d_reg;
                d_next     = c_reg;
                c_next     = b_reg;
                b_next     = b_reg + rot;
                round_next = round_reg + 6'd1;
            end
            OP_FOLD:
            begin
                chain_next[0] = chain_reg[0] + a_reg;
                chain_next[1] = chain_reg[1] + b_reg;
                chain_next[2] = chain_reg[2] + c_reg;
                chain_next[3] = chain_reg[3] + d_reg;
                if (extra_reg)
                begin
                    extra_next = 1'b0;
                    wptr_next  = 5'd0;
                end
            end
            OP_MARK:
            begin
                // 0x80 at the byte position, zeros above it in that word
                we         = 1'b1;
                wbe        = 4'b1111 << pos[1:0];
                wdata      = {24'h0, PAD_MARK} << {pos[1:0], 3'b000};
                wptr_next  = {1'b0, pos[5:2]} + 5'd1;
                extra_next = (pos[5:3] == 3'd7);
            end
            OP_ZERO:
            begin
                if (!wptr_reg[4])
                begin
                    we        = 1'b1;
                    waddr     = wptr_reg[3:0];
                    wbe       = 4'b1111;
                    wptr_next = wptr_reg + 5'd1;
                end
            end
            OP_LEN_LO:
            begin
                we    = 1'b1;
                waddr = 4'd14;
                wbe   = 4'b1111;
                wdata = {count_reg[28:0], 3'b000};
            end
            OP_LEN_HI:
            begin
                we         = 1'b1;
                waddr      = 4'd15;
                wbe        = 4'b1111;
                wdata      = count_reg[60:29];
                final_next = 1'b1;
            end
            OP_EMIT0:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = '{digest_half: {chain_reg[1], chain_reg[0]},
                                       half_last: 1'b0};
                end
            end
            OP_EMIT1:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = '{digest_half: {chain_reg[3], chain_reg[2]},
                                       half_last: 1'b1};
                    chain_next[0]  = INIT_A;
                    chain_next[1]  = INIT_B;
                    chain_next[2]  = INIT_C;
                    chain_next[3]  = INIT_D;
                    count_next     = 61'd0;
                    pend_next      = 1'b0;
                    final_next     = 1'b0;
                end
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    // Block buffer
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 4; j++)
        begin
            if (we && wbe[j])
            begin
                mem[waddr][8*j +: 8] <= wdata[8*j +: 8];
            end
        end
        rdata_reg <= mem[rd_addr];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg[0]  <= INIT_A;
            chain_reg[1]  <= INIT_B;
            chain_reg[2]  <= INIT_C;
            chain_reg[3]  <= INIT_D;
            count_reg     <= '0;
            round_reg     <= '0;
            wptr_reg      <= '0;
            pend_reg      <= 1'b0;
            extra_reg     <= 1'b0;
            final_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < 4; i++)
            begin
                chain_reg[i] <= chain_next[i];
            end
            count_reg     <= count_next;
            round_reg     <= round_next;
            wptr_reg      <= wptr_next;
            pend_reg      <= pend_next;
            extra_reg     <= extra_next;
            final_reg     <= final_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working words and output payload
    always_ff @(posedge clk)
    begin
        a_reg        <= a_next;
        b_reg        <= b_next;
        c_reg        <= c_next;
        d_reg        <= d_next;
        out_word_reg <= out_word_next;
    end

endmodule
`default_nettype wire

[rtl/md5_message_hasher_core.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// md5_message_hasher_core
// MD5 digest of a byte stream, microcoded round engine.
// ---------------------------------------------------------------------------
// Usage: feed the message one byte per word on the input channel; set last
// on the final word (with or without a byte; a byteless last word closes the
// message, and a byteless word without last is ignored). Bytes are taken one
// per cycle while in_ready is high. Every 64th byte starts a block
// compression that holds in_ready low (load, 64 rounds sharing one round
// unit, fold, resume). Closing a message holds in_ready low through mark,
// zero sweep from the word after the marker to the end of the block,
// length, load, 64 rounds, fold, two emit steps (the later the tail sits
// in its block, the shorter the sweep), through a second block when the
// padding spills into it (tail at byte 56 or later), and through any
// output stall. A last byte that completes a block adds its compression
// first. Two output words follow: digest bytes 0-7, then 8-15 with
// half_last set, earliest byte in the low bits. Afterwards the hasher is
// ready for a new message. The round count, dictated by the single shared
// round unit and the one-read block buffer, sets the rate.
// ---------------------------------------------------------------------------
module md5_message_hasher_core
    import md5h_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_word_t  in_word,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_word_t      out_word
);

    op_t   op;
    stat_t stat;

    md5h_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .op    (op)
    );

    md5h_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .stat      (stat),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    // Last round always hands over to the fold step
    assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_ROUND && !stat.more_rounds) |=> (op == OP_FOLD))
        else $error("round loop did not end in fold");

    // Output words only appear from an emit step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> ($past(op) == OP_EMIT0 || $past(op) == OP_EMIT1))
        else $error("output word raised outside emit");

    // Nothing follows the second digest half right away
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && out_word.half_last) |=> !out_valid)
        else $error("extra output word after digest");

    // No input taken while a compression is running
    assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_ROUND) |-> !in_ready)
        else $error("input accepted during rounds");

endmodule
`default_nettype wire
